FILE: hw/rtl/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// rgbe_pkg
// shared constants for the rgbe run-length scanline decoder
// ----------------------------------------------------------------------------
package rgbe_pkg;

	localparam int MAX_WIDTH_DEF = 4096;

	localparam int BYTE_W = 8;
	localparam int F32_W  = 32;
	localparam int LW_W   = 13;
	localparam int FH_W   = 16;
	localparam int CFG_W  = 16;

	// configuration register indexes
	localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RAW_MODE     = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_HDR = 2'd1;
	localparam logic [1:0] STAT_OVERRUN = 2'd2;

	localparam logic [7:0] HDR_MAGIC = 8'd2;
	localparam logic [7:0] RUN_BASE  = 8'd128;

	localparam logic [1:0] CH_EXP = 2'd3;

endpackage

FILE: hw/rtl/rgbe_ram.sv
// ----------------------------------------------------------------------------
// rgbe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rgbe_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 12288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/rgbe_cvt.sv
// ----------------------------------------------------------------------------
// rgbe_cvt
// mantissa byte and shared exponent to exact single: (m+0.5)*2^(e-136)
// ----------------------------------------------------------------------------
module rgbe_cvt (
	input  logic [rgbe_pkg::BYTE_W-1:0] mant,
	input  logic [rgbe_pkg::BYTE_W-1:0] expo,
	output logic [rgbe_pkg::F32_W-1:0]  f32
);

	logic [8:0]  v;
	logic [3:0]  nbits;
	logic [10:0] esum;
	logic [31:0] vnorm;
	logic [31:0] vden;
	logic [10:0] ebias;

	assign v = {mant, 1'b1};

	always_comb begin
		nbits = 4'd1;
		for (int i = 0; i < 9; i++) begin
			if (v[i]) begin
				nbits = 4'(i + 1);
			end
		end
	end

	// biased exponent is nbits - 11 + e
	assign esum  = 11'(expo) + 11'(nbits);
	assign ebias = esum - 11'd11;
	assign vnorm = 32'(v) << (5'd24 - 5'(nbits));
	assign vden  = 32'(v) << (6'(expo) + 6'd12);

	always_comb begin
		if (esum >= 11'd12) begin
			f32 = {1'b0, ebias[7:0], vnorm[22:0]};
		end else begin
			f32 = vden;
		end
	end

endmodule

FILE: hw/rtl/rgbe_rle_scanline_decoder.sv
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder
// rgbe pixel stream decoder: adaptive rle scanlines or flat pixels to singles
// ----------------------------------------------------------------------------
// One byte enters per request on s_*, pixels leave up to two at once on m_*.
// Header bytes, run counts and the first three bytes of a raw pixel are
// taken in the idle state. A red, green or blue run is written to the line
// store one byte per cycle. Each pixel of an exponent byte takes three reads
// of the single store port plus one result register, then three passes
// through the one float converter; each result of up to two pixels is handed
// to the output register in a push step that waits while the output is full,
// and the input is held for the whole exponent run. A raw pixel's fourth byte
// takes the three converter passes and one push. The output register lets
// the next byte in while a result waits. After a bad header or a run past
// the line end every byte gives one error result until reset.
// ----------------------------------------------------------------------------
module rgbe_rle_scanline_decoder #(
	parameter int MAX_WIDTH = rgbe_pkg::MAX_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [rgbe_pkg::CFG_W-1:0] cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// first_red, first_green, first_blue, second_red, second_green, second_blue
	output logic [191:0] m_tdata,
	output logic         m_tlast,   // line_done
	output logic [4:0]   m_tuser    // second_valid, frame_done, run_end, status[1:0]
);

	localparam int PW    = $clog2(MAX_WIDTH + 512);
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_CV,
		ST_PUSH
	} state_t;

	state_t state_q;

	logic [rgbe_pkg::LW_W-1:0] lw_q;
	logic [rgbe_pkg::FH_W-1:0] fh_q;
	logic                      raw_mode_q;

	logic        phase_q;
	logic [1:0]  hi_q;
	logic [1:0]  ch_q;
	logic [PW-1:0] pos_q;
	logic [7:0]  pend_q;
	logic        runp_q;
	logic [15:0] lc_q;
	logic [23:0] rawb_q;
	logic        err_q;
	logic [1:0]  errc_q;

	logic [PW-1:0] job_pos_q;
	logic [7:0]  job_rem_q;
	logic [7:0]  job_val_q;
	logic [1:0]  job_ch_q;
	logic        job_ends_q;
	logic        job_lastl_q;
	logic        job_raw_q;
	logic        slot_q;
	logic [1:0]  rd_cnt_q;
	logic [1:0]  cv_cnt_q;
	logic        res_err_q;
	logic [1:0]  res_st_q;
	logic        res_sv_q;
	logic        res_ld_q;
	logic        res_fd_q;
	logic        res_re_q;

	logic [7:0]  mr_q, mg_q, mb_q;
	logic [31:0] stage_q [6];
	logic [191:0] out_data_q;
	logic        m_tvalid_q;
	logic        m_tlast_q;
	logic [4:0]  m_tuser_q;

	logic [PW-1:0] w_eff;
	logic [15:0] h_eff;
	logic        last_line;
	logic [15:0] lc_next;
	logic [31:0] w32;
	logic [7:0]  want;
	logic [7:0]  cnt_n;
	logic        plc_do;
	logic [7:0]  plc_n;
	logic        plc_ends;
	logic        ovr;
	logic        raw_ends;
	logic        out_free;
	logic [7:0]  rem_next;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [PW+1:0] addr_base;
	logic [PW+1:0] raddr_full;

	logic [7:0]  cv_mant;
	logic [31:0] cv_f32;
	logic        pix_zero;
	logic [2:0]  stage_idx;

	// effective width and height
	always_comb begin
		if (lw_q == '0) begin
			w_eff = PW'(1);
		end else if (32'(lw_q) > 32'(MAX_WIDTH)) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(lw_q);
		end
		h_eff = (fh_q == '0) ? 16'd1 : fh_q;
	end

	assign last_line = (17'(lc_q) + 17'd1) >= 17'(h_eff);
	assign lc_next   = last_line ? 16'd0 : lc_q + 16'd1;
	assign w32       = 32'(w_eff);

	always_comb begin
		unique case (hi_q)
			2'd0, 2'd1: want = rgbe_pkg::HDR_MAGIC;
			2'd2:       want = w32[15:8];
			default:    want = w32[7:0];
		endcase
	end

	// run count decode for the rle data phase
	assign cnt_n = (s_tdata > rgbe_pkg::RUN_BASE) ? {1'b0, s_tdata[6:0]} : s_tdata;
	assign ovr   = (pos_q + PW'(cnt_n)) > w_eff;

	always_comb begin
		plc_do = 1'b0;
		plc_n  = 8'd0;
		if (runp_q) begin
			plc_do = 1'b1;
			plc_n  = pend_q;
		end else if (pend_q != 8'd0) begin
			plc_do = 1'b1;
			plc_n  = 8'd1;
		end
	end

	assign plc_ends = (pos_q + PW'(plc_n)) >= w_eff;
	assign raw_ends = (pos_q + PW'(1)) >= w_eff;
	assign out_free = !m_tvalid_q || m_tready;
	assign rem_next = job_rem_q - 8'd1;

	// line store addressing: three bytes per pixel
	assign addr_base  = {1'b0, job_pos_q, 1'b0} + (PW + 2)'(job_pos_q);
	assign raddr_full = addr_base + (PW + 2)'(rd_cnt_q);
	assign ram_we     = (state_q == ST_WR) && (job_pos_q < PW'(MAX_WIDTH));
	assign ram_waddr  = AW'(addr_base + (PW + 2)'(job_ch_q));
	assign ram_raddr  = AW'(raddr_full);

	rgbe_ram #(
		.W     (rgbe_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (job_val_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (cv_cnt_q)
			2'd0:    cv_mant = mr_q;
			2'd1:    cv_mant = mg_q;
			default: cv_mant = mb_q;
		endcase
	end

	rgbe_cvt u_cvt (
		.mant (cv_mant),
		.expo (job_val_q),
		.f32  (cv_f32)
	);

	assign pix_zero  = ((mr_q | mg_q | mb_q) == 8'd0) ||
		(!job_raw_q && (job_pos_q >= PW'(MAX_WIDTH)));
	assign stage_idx = slot_q ? (3'd3 + 3'(cv_cnt_q)) : 3'(cv_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lw_q        <= 13'd8;
			fh_q        <= 16'd1;
			raw_mode_q  <= 1'b0;
			phase_q     <= 1'b0;
			hi_q        <= 2'd0;
			ch_q        <= 2'd0;
			pos_q       <= '0;
			pend_q      <= 8'd0;
			runp_q      <= 1'b0;
			lc_q        <= 16'd0;
			rawb_q      <= 24'd0;
			err_q       <= 1'b0;
			errc_q      <= rgbe_pkg::STAT_OK;
			job_pos_q   <= '0;
			job_rem_q   <= 8'd0;
			job_val_q   <= 8'd0;
			job_ch_q    <= 2'd0;
			job_ends_q  <= 1'b0;
			job_lastl_q <= 1'b0;
			job_raw_q   <= 1'b0;
			slot_q      <= 1'b0;
			rd_cnt_q    <= 2'd0;
			cv_cnt_q    <= 2'd0;
			res_err_q   <= 1'b0;
			res_st_q    <= rgbe_pkg::STAT_OK;
			res_sv_q    <= 1'b0;
			res_ld_q    <= 1'b0;
			res_fd_q    <= 1'b0;
			res_re_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			m_tuser_q   <= 5'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rgbe_pkg::REG_LINE_WIDTH:   lw_q       <= cfg_data[12:0];
					rgbe_pkg::REG_FRAME_HEIGHT: fh_q       <= cfg_data;
					rgbe_pkg::REG_RAW_MODE:     raw_mode_q <= cfg_data[0];
					default: ;
				endcase
			end

			// in ST_PUSH an accepted result is replaced by the next one below
			if (m_tvalid_q && m_tready && state_q != ST_PUSH) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (err_q) begin
							res_err_q <= 1'b1;
							res_st_q  <= errc_q;
							job_rem_q <= 8'd0;
							state_q   <= ST_PUSH;
						end else if (raw_mode_q) begin
							if (hi_q != 2'd3) begin
								case (hi_q)
									2'd0:    rawb_q[7:0]   <= s_tdata;
									2'd1:    rawb_q[15:8]  <= s_tdata;
									default: rawb_q[23:16] <= s_tdata;
								endcase
								hi_q <= hi_q + 2'd1;
							end else begin
								job_val_q   <= s_tdata;
								job_rem_q   <= 8'd1;
								job_raw_q   <= 1'b1;
								job_ends_q  <= raw_ends;
								job_lastl_q <= last_line;
								slot_q      <= 1'b0;
								cv_cnt_q    <= 2'd0;
								hi_q        <= 2'd0;
								rawb_q      <= 24'd0;
								state_q     <= ST_CV;
								if (raw_ends) begin
									pos_q <= '0;
									lc_q  <= lc_next;
								end else begin
									pos_q <= pos_q + PW'(1);
								end
							end
						end else if (!phase_q) begin
							if (s_tdata != want) begin
								err_q     <= 1'b1;
								errc_q    <= rgbe_pkg::STAT_BAD_HDR;
								res_err_q <= 1'b1;
								res_st_q  <= rgbe_pkg::STAT_BAD_HDR;
								job_rem_q <= 8'd0;
								state_q   <= ST_PUSH;
							end else if (hi_q == 2'd3) begin
								hi_q    <= 2'd0;
								ch_q    <= 2'd0;
								pos_q   <= '0;
								pend_q  <= 8'd0;
								runp_q  <= 1'b0;
								phase_q <= 1'b1;
							end else begin
								hi_q <= hi_q + 2'd1;
							end
						end else if (plc_do) begin
							if (runp_q) begin
								pend_q <= 8'd0;
								runp_q <= 1'b0;
							end else begin
								pend_q <= pend_q - 8'd1;
							end
							job_pos_q   <= pos_q;
							job_rem_q   <= plc_n;
							job_val_q   <= s_tdata;
							job_ch_q    <= ch_q;
							job_ends_q  <= plc_ends;
							job_lastl_q <= last_line;
							job_raw_q   <= 1'b0;
							slot_q      <= 1'b0;
							rd_cnt_q    <= 2'd0;
							state_q     <= (ch_q == rgbe_pkg::CH_EXP) ? ST_RD : ST_WR;
							if (plc_ends) begin
								pos_q <= '0;
								if (ch_q == rgbe_pkg::CH_EXP) begin
									lc_q    <= lc_next;
									phase_q <= 1'b0;
									hi_q    <= 2'd0;
									ch_q    <= 2'd0;
									pend_q  <= 8'd0;
									runp_q  <= 1'b0;
								end else begin
									ch_q <= ch_q + 2'd1;
								end
							end else begin
								pos_q <= pos_q + PW'(plc_n);
							end
						end else if (s_tdata != 8'd0) begin
							if (ovr) begin
								err_q     <= 1'b1;
								errc_q    <= rgbe_pkg::STAT_OVERRUN;
								res_err_q <= 1'b1;
								res_st_q  <= rgbe_pkg::STAT_OVERRUN;
								job_rem_q <= 8'd0;
								state_q   <= ST_PUSH;
							end else begin
								pend_q <= cnt_n;
								runp_q <= (s_tdata > rgbe_pkg::RUN_BASE);
							end
						end
					end
				end

				ST_WR: begin
					job_pos_q <= job_pos_q + PW'(1);
					job_rem_q <= rem_next;
					if (job_rem_q == 8'd1) begin
						state_q <= ST_IDLE;
					end
				end

				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) begin
						cv_cnt_q <= 2'd0;
						state_q  <= ST_CV;
					end
				end

				ST_CV: begin
					if (cv_cnt_q == 2'd2) begin
						cv_cnt_q  <= 2'd0;
						job_rem_q <= rem_next;
						job_pos_q <= job_pos_q + PW'(1);
						rd_cnt_q  <= 2'd0;
						if (!slot_q && rem_next != 8'd0) begin
							slot_q  <= 1'b1;
							state_q <= ST_RD;
						end else begin
							res_err_q <= 1'b0;
							res_st_q  <= rgbe_pkg::STAT_OK;
							res_sv_q  <= slot_q;
							res_re_q  <= (rem_next == 8'd0);
							res_ld_q  <= (rem_next == 8'd0) && job_ends_q;
							res_fd_q  <= (rem_next == 8'd0) && job_ends_q && job_lastl_q;
							state_q   <= ST_PUSH;
						end
					end else begin
						cv_cnt_q <= cv_cnt_q + 2'd1;
					end
				end

				ST_PUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (res_err_q) begin
							m_tlast_q <= 1'b0;
							m_tuser_q <= {res_st_q, 1'b1, 1'b0, 1'b0};
						end else begin
							m_tlast_q <= res_ld_q;
							m_tuser_q <= {res_st_q, res_re_q, res_fd_q, res_sv_q};
						end
						slot_q   <= 1'b0;
						rd_cnt_q <= 2'd0;
						if (res_err_q || job_rem_q == 8'd0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pixel payload: store reads, converter results, output data
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && raw_mode_q && !err_q && hi_q == 2'd3) begin
			mr_q <= rawb_q[7:0];
			mg_q <= rawb_q[15:8];
			mb_q <= rawb_q[23:16];
		end
		if (state_q == ST_RD) begin
			case (rd_cnt_q)
				2'd1:    mr_q <= ram_rdata;
				2'd2:    mg_q <= ram_rdata;
				2'd3:    mb_q <= ram_rdata;
				default: ;
			endcase
		end
		if (state_q == ST_CV) begin
			stage_q[stage_idx] <= pix_zero ? 32'd0 : cv_f32;
		end
		if (state_q == ST_PUSH && out_free) begin
			if (res_err_q) begin
				out_data_q <= '0;
			end else if (res_sv_q) begin
				out_data_q <= {stage_q[5], stage_q[4], stage_q[3],
					stage_q[2], stage_q[1], stage_q[0]};
			end else begin
				out_data_q <= {96'd0, stage_q[2], stage_q[1], stage_q[0]};
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule
